### hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the gesture detector.
// No dependencies; the macro bodies are left empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Hold prop at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Flag expr as illegal at every rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

### hw/rtl/thgg_pkg.sv
// Shared types and constants of the two-hand gripper gesture detector.
// No dependencies; imported by every module of the block.
`default_nettype none

package thgg_pkg;

    localparam int CFG_W    = 16;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 5;
    localparam int TS_W     = 32;
    localparam int VEC_W    = 48;
    localparam int DIST_W   = 34;
    localparam int SQ_THR_W = 2 * CFG_W;

    // Slave tdata layout, lowest bits first
    localparam int TS_LSB        = 0;
    localparam int LNORM_LSB     = TS_LSB + TS_W;
    localparam int RNORM_LSB     = LNORM_LSB + VEC_W;
    localparam int LPOS_LSB      = RNORM_LSB + VEC_W;
    localparam int RPOS_LSB      = LPOS_LSB + VEC_W;
    localparam int S_TDATA_W     = RPOS_LSB + VEC_W;

    // Master tdata: armed, open, close, zone, distance squared, pad to bytes
    localparam int M_FIELDS_W    = 3 + 2 + DIST_W;
    localparam int M_TDATA_W     = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W       = M_TDATA_W - M_FIELDS_W;

    typedef logic [1:0] t_zone;
    localparam t_zone ZONE_UNKNOWN = 2'd0;
    localparam t_zone ZONE_OPEN    = 2'd1;
    localparam t_zone ZONE_CLOSE   = 2'd2;
    localparam t_zone ZONE_NEUTRAL = 2'd3;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_FACING_DOT_LIMIT = 3'd0;
    localparam t_reg_idx REG_HOLD_TIME_MS     = 3'd1;
    localparam t_reg_idx REG_OPEN_DISTANCE    = 3'd2;
    localparam t_reg_idx REG_CLOSE_DISTANCE   = 3'd3;
    localparam t_reg_idx REG_NEUTRAL_LOW      = 3'd4;
    localparam t_reg_idx REG_NEUTRAL_HIGH     = 3'd5;
    localparam t_reg_idx REG_COOLDOWN_MS      = 3'd6;

    localparam logic [CFG_W-1:0] RST_FACING_DOT_LIMIT = CFG_W'(-11469);
    localparam logic [CFG_W-1:0] RST_HOLD_TIME_MS     = CFG_W'(300);
    localparam logic [CFG_W-1:0] RST_OPEN_DISTANCE    = CFG_W'(2000);
    localparam logic [CFG_W-1:0] RST_CLOSE_DISTANCE   = CFG_W'(800);
    localparam logic [CFG_W-1:0] RST_NEUTRAL_LOW      = CFG_W'(1100);
    localparam logic [CFG_W-1:0] RST_NEUTRAL_HIGH     = CFG_W'(1700);
    localparam logic [CFG_W-1:0] RST_COOLDOWN_MS      = CFG_W'(500);

    // Live settings, distance thresholds already squared
    typedef struct packed {
        logic [CFG_W-1:0]    facing_dot_limit;
        logic [CFG_W-1:0]    hold_time_ms;
        logic [SQ_THR_W-1:0] open_sq;
        logic [SQ_THR_W-1:0] close_sq;
        logic [SQ_THR_W-1:0] nlow_sq;
        logic [SQ_THR_W-1:0] nhigh_sq;
        logic [CFG_W-1:0]    cooldown_ms;
    } t_cfg;

    // Stage control: adv loads the stage, vld marks a live transaction
    typedef struct packed {
        logic adv;
        logic vld;
    } t_pipe_ctrl;

endpackage

`default_nettype wire

### hw/rtl/thgg_cfg.sv
// APB register file of the gesture detector, with squared distance thresholds.
// Depends on thgg_pkg.
`default_nettype none

module thgg_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [thgg_pkg::APB_AW-1:0]   paddr,
    input  logic [thgg_pkg::APB_DW-1:0]   pwdata,
    output logic [thgg_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output thgg_pkg::t_cfg                o_cfg
);
    import thgg_pkg::*;

    logic [CFG_W-1:0]    r_facing_dot_limit;
    logic [CFG_W-1:0]    r_hold_time_ms;
    logic [CFG_W-1:0]    r_open_distance;
    logic [CFG_W-1:0]    r_close_distance;
    logic [CFG_W-1:0]    r_neutral_low;
    logic [CFG_W-1:0]    r_neutral_high;
    logic [CFG_W-1:0]    r_cooldown_ms;
    logic [SQ_THR_W-1:0] r_open_sq;
    logic [SQ_THR_W-1:0] r_close_sq;
    logic [SQ_THR_W-1:0] r_nlow_sq;
    logic [SQ_THR_W-1:0] r_nhigh_sq;
    logic                wr_en;
    t_reg_idx            reg_idx;
    logic [CFG_W-1:0]    wr_val;
    logic [CFG_W-1:0]    rd_val;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_val  = pwdata[CFG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_facing_dot_limit <= RST_FACING_DOT_LIMIT;
            r_hold_time_ms     <= RST_HOLD_TIME_MS;
            r_open_distance    <= RST_OPEN_DISTANCE;
            r_close_distance   <= RST_CLOSE_DISTANCE;
            r_neutral_low      <= RST_NEUTRAL_LOW;
            r_neutral_high     <= RST_NEUTRAL_HIGH;
            r_cooldown_ms      <= RST_COOLDOWN_MS;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FACING_DOT_LIMIT: r_facing_dot_limit <= wr_val;
                REG_HOLD_TIME_MS:     r_hold_time_ms     <= wr_val;
                REG_OPEN_DISTANCE:    r_open_distance    <= wr_val;
                REG_CLOSE_DISTANCE:   r_close_distance   <= wr_val;
                REG_NEUTRAL_LOW:      r_neutral_low      <= wr_val;
                REG_NEUTRAL_HIGH:     r_neutral_high     <= wr_val;
                REG_COOLDOWN_MS:      r_cooldown_ms      <= wr_val;
                default: ;
            endcase
        end
    end

    // Square the thresholds in a register stage behind the setting registers
    always_ff @(posedge i_clk) begin
        r_open_sq  <= SQ_THR_W'(r_open_distance)  * SQ_THR_W'(r_open_distance);
        r_close_sq <= SQ_THR_W'(r_close_distance) * SQ_THR_W'(r_close_distance);
        r_nlow_sq  <= SQ_THR_W'(r_neutral_low)    * SQ_THR_W'(r_neutral_low);
        r_nhigh_sq <= SQ_THR_W'(r_neutral_high)   * SQ_THR_W'(r_neutral_high);
    end

    always_comb begin
        case (reg_idx)
            REG_FACING_DOT_LIMIT: rd_val = r_facing_dot_limit;
            REG_HOLD_TIME_MS:     rd_val = r_hold_time_ms;
            REG_OPEN_DISTANCE:    rd_val = r_open_distance;
            REG_CLOSE_DISTANCE:   rd_val = r_close_distance;
            REG_NEUTRAL_LOW:      rd_val = r_neutral_low;
            REG_NEUTRAL_HIGH:     rd_val = r_neutral_high;
            REG_COOLDOWN_MS:      rd_val = r_cooldown_ms;
            default:              rd_val = '0;
        endcase
    end

    assign prdata = APB_DW'(rd_val);

    assign o_cfg.facing_dot_limit = r_facing_dot_limit;
    assign o_cfg.hold_time_ms     = r_hold_time_ms;
    assign o_cfg.open_sq          = r_open_sq;
    assign o_cfg.close_sq         = r_close_sq;
    assign o_cfg.nlow_sq          = r_nlow_sq;
    assign o_cfg.nhigh_sq         = r_nhigh_sq;
    assign o_cfg.cooldown_ms      = r_cooldown_ms;

endmodule

`default_nettype wire

### hw/rtl/thgg_geom.sv
// Multiplier stage: per-axis normal products and squared position differences.
// Depends on thgg_pkg; one registered lane per axis.
`default_nettype none

module thgg_geom #(
    parameter int COORD_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                              i_clk,
    input  logic                              i_load,
    input  logic                              i_both,
    input  logic [TIME_BITS-1:0]              i_now,
    input  logic [thgg_pkg::VEC_W-1:0]        i_left_normal,
    input  logic [thgg_pkg::VEC_W-1:0]        i_right_normal,
    input  logic [thgg_pkg::VEC_W-1:0]        i_left_position,
    input  logic [thgg_pkg::VEC_W-1:0]        i_right_position,
    output logic                              o_both,
    output logic [TIME_BITS-1:0]              o_now,
    output logic signed [2*COORD_BITS-1:0]    o_dot_term [3],
    output logic [2*COORD_BITS:0]             o_sq_term  [3]
);
    import thgg_pkg::*;

    localparam int EXT_W  = (3 * COORD_BITS > VEC_W) ? 3 * COORD_BITS : VEC_W;
    localparam int PROD_W = 2 * COORD_BITS;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int DSQ_W  = 2 * DIFF_W;
    localparam int SQ_W   = 2 * COORD_BITS + 1;

    logic [EXT_W-1:0] ln_ext;
    logic [EXT_W-1:0] rn_ext;
    logic [EXT_W-1:0] lp_ext;
    logic [EXT_W-1:0] rp_ext;
    logic             r_both;
    logic [TIME_BITS-1:0] r_now;

    // Components beyond the packed field read as zero
    assign ln_ext = EXT_W'(i_left_normal);
    assign rn_ext = EXT_W'(i_right_normal);
    assign lp_ext = EXT_W'(i_left_position);
    assign rp_ext = EXT_W'(i_right_position);

    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic signed [COORD_BITS-1:0] ln_c;
        logic signed [COORD_BITS-1:0] rn_c;
        logic signed [COORD_BITS-1:0] lp_c;
        logic signed [COORD_BITS-1:0] rp_c;
        logic signed [DIFF_W-1:0]     diff;
        logic signed [DSQ_W-1:0]      diff_sq;
        logic signed [PROD_W-1:0]     r_dot;
        logic [SQ_W-1:0]              r_sq;

        assign ln_c    = ln_ext[k*COORD_BITS +: COORD_BITS];
        assign rn_c    = rn_ext[k*COORD_BITS +: COORD_BITS];
        assign lp_c    = lp_ext[k*COORD_BITS +: COORD_BITS];
        assign rp_c    = rp_ext[k*COORD_BITS +: COORD_BITS];
        assign diff    = DIFF_W'(lp_c) - DIFF_W'(rp_c);
        assign diff_sq = DSQ_W'(diff) * DSQ_W'(diff);

        always_ff @(posedge i_clk) begin
            if (i_load) begin
                r_dot <= PROD_W'(ln_c) * PROD_W'(rn_c);
                r_sq  <= diff_sq[SQ_W-1:0];
            end
        end

        assign o_dot_term[k] = r_dot;
        assign o_sq_term[k]  = r_sq;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_both <= i_both;
            r_now  <= i_now;
        end
    end

    assign o_both = r_both;
    assign o_now  = r_now;

endmodule

`default_nettype wire

### hw/rtl/thgg_decide.sv
// Decision stage: facing timer, zone classing, impulse firing and result register.
// Depends on thgg_pkg; holds all frame-to-frame state of the detector.
`default_nettype none

module thgg_decide #(
    parameter int COORD_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  thgg_pkg::t_pipe_ctrl              i_ctrl,
    input  thgg_pkg::t_cfg                    i_cfg,
    input  logic                              i_both,
    input  logic [TIME_BITS-1:0]              i_now,
    input  logic signed [2*COORD_BITS-1:0]    i_dot_term [3],
    input  logic [2*COORD_BITS:0]             i_sq_term  [3],
    output logic                              o_armed,
    output logic                              o_open_impulse,
    output logic                              o_close_impulse,
    output thgg_pkg::t_zone                   o_zone,
    output logic                              o_distance_valid,
    output logic [thgg_pkg::DIST_W-1:0]       o_distance_squared
);
    import thgg_pkg::*;

    localparam int DOT_W = 2 * COORD_BITS + 2;
    localparam int SUM_W = 2 * COORD_BITS + 3;
    localparam int ALIGN = 2 * COORD_BITS - 18;
    localparam int CMP_W = 64;
    localparam logic [CMP_W-1:0] DIST_MAX = (CMP_W'(1) << DIST_W) - CMP_W'(1);

    logic                     r_facing_valid;
    logic [TIME_BITS-1:0]     r_facing_start;
    t_zone                    r_prev_zone;
    logic                     r_fired_valid;
    logic [TIME_BITS-1:0]     r_last_fire;
    logic                     r_armed;
    logic                     r_open;
    logic                     r_close;
    t_zone                    r_zone;
    logic                     r_dvalid;
    logic [DIST_W-1:0]        r_dsq;

    logic                     n_facing_valid;
    logic [TIME_BITS-1:0]     n_facing_start;
    logic                     n_fired_valid;
    logic [TIME_BITS-1:0]     n_last_fire;

    logic signed [DOT_W-1:0]  dot;
    logic signed [CFG_W-1:0]  limit;
    logic signed [DOT_W-1:0]  limit_ext;
    logic [SUM_W-1:0]         dsq;
    logic [CMP_W-1:0]         dsq_cmp;
    logic                     facing;
    logic [TIME_BITS-1:0]     start_eff;
    logic [TIME_BITS-1:0]     held_for;
    logic [TIME_BITS-1:0]     since_fire;
    logic                     armed;
    logic                     cool_ok;
    t_zone                    zone_cls;
    t_zone                    zone;
    logic                     fire_open;
    logic                     fire_close;
    logic [DIST_W-1:0]        dsq_sat;
    logic                     commit;

    assign dot = DOT_W'(i_dot_term[0]) + DOT_W'(i_dot_term[1]) + DOT_W'(i_dot_term[2]);
    assign dsq = SUM_W'(i_sq_term[0]) + SUM_W'(i_sq_term[1]) + SUM_W'(i_sq_term[2]);
    assign dsq_cmp = CMP_W'(dsq);

    // Bring the Q1.14 limit to the scale of the product sum
    assign limit     = i_cfg.facing_dot_limit;
    assign limit_ext = DOT_W'(limit) <<< ALIGN;
    assign facing    = dot < limit_ext;

    assign start_eff  = r_facing_valid ? r_facing_start : i_now;
    assign held_for   = i_now - start_eff;
    assign armed      = i_both && facing &&
                        (CMP_W'(held_for) >= CMP_W'(i_cfg.hold_time_ms));

    assign since_fire = i_now - r_last_fire;
    assign cool_ok    = !r_fired_valid ||
                        (CMP_W'(since_fire) > CMP_W'(i_cfg.cooldown_ms));

    // Fixed test order: open, close, neutral
    always_comb begin
        if (dsq_cmp > CMP_W'(i_cfg.open_sq)) begin
            zone_cls = ZONE_OPEN;
        end else if (dsq_cmp < CMP_W'(i_cfg.close_sq)) begin
            zone_cls = ZONE_CLOSE;
        end else if (dsq_cmp > CMP_W'(i_cfg.nlow_sq) && dsq_cmp < CMP_W'(i_cfg.nhigh_sq)) begin
            zone_cls = ZONE_NEUTRAL;
        end else begin
            zone_cls = ZONE_UNKNOWN;
        end
    end

    assign zone       = armed ? zone_cls : ZONE_UNKNOWN;
    assign fire_open  = armed && cool_ok && (zone == ZONE_OPEN) &&
                        (r_prev_zone == ZONE_NEUTRAL || r_prev_zone == ZONE_CLOSE);
    assign fire_close = armed && cool_ok && (zone == ZONE_CLOSE) &&
                        (r_prev_zone == ZONE_NEUTRAL || r_prev_zone == ZONE_OPEN);

    assign dsq_sat = (dsq_cmp > DIST_MAX) ? '1 : DIST_W'(dsq);

    assign n_facing_valid = i_both && facing;
    assign n_facing_start = (i_both && facing && !r_facing_valid) ? i_now : r_facing_start;
    assign n_fired_valid  = r_fired_valid || fire_open || fire_close;
    assign n_last_fire    = (fire_open || fire_close) ? i_now : r_last_fire;

    assign commit = i_ctrl.adv && i_ctrl.vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_facing_valid <= 1'b0;
            r_facing_start <= '0;
            r_prev_zone    <= ZONE_UNKNOWN;
            r_fired_valid  <= 1'b0;
            r_last_fire    <= '0;
        end else if (commit) begin
            r_facing_valid <= n_facing_valid;
            r_facing_start <= n_facing_start;
            r_prev_zone    <= zone;
            r_fired_valid  <= n_fired_valid;
            r_last_fire    <= n_last_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            r_armed  <= armed;
            r_open   <= fire_open;
            r_close  <= fire_close;
            r_zone   <= zone;
            r_dvalid <= i_both;
            r_dsq    <= i_both ? dsq_sat : '0;
        end
    end

    assign o_armed            = r_armed;
    assign o_open_impulse     = r_open;
    assign o_close_impulse    = r_close;
    assign o_zone             = r_zone;
    assign o_distance_valid   = r_dvalid;
    assign o_distance_squared = r_dsq;

endmodule

`default_nettype wire

### hw/rtl/two_hand_gripper_gesture_detector.sv
// Two-hand gripper gesture detector: top level, stream handshake and pipeline control.
// Depends on thgg_pkg, thgg_cfg, thgg_geom, thgg_decide and assert_macros.svh.
//
// Usage:
//   One tracking frame enters per slave transaction; one result leaves per master
//   transaction, in the same order. s_axis_tuser carries the both-hands flag and
//   m_axis_tuser the distance-valid flag; tdata layouts are listed at the ports.
//   Settings are written over the APB port while no frame is in flight; the
//   squared distance thresholds follow in the cycle after a write.
// Timing:
//   Three register stages (input, multiplier, decision/result). One frame per
//   cycle is sustained while the receiver keeps m_axis_tready high; the
//   per-axis multipliers set the stage split.
// Reset (synchronous, active low):
//   Clears the stage valid flags, the facing timer, the previous zone and the cooldown
//   history, and loads the default settings.
// Stall:
//   While the receiver holds m_axis_tready low, empty stages still fill, so up to
//   two further frames are taken before s_axis_tready drops; nothing is lost.
`default_nettype none

module two_hand_gripper_gesture_detector #(
    parameter int COORD_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // APB settings port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [thgg_pkg::APB_AW-1:0]       paddr,
    input  logic [thgg_pkg::APB_DW-1:0]       pwdata,
    output logic [thgg_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    // Frame input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // timestamp_ms[31:0], left_normal[79:32], right_normal[127:80],
    // left_position[175:128], right_position[223:176]
    input  logic [thgg_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // both_hands[0]
    input  logic                              s_axis_tuser,
    // Result output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // armed[0], open_impulse[1], close_impulse[2], zone[4:3],
    // distance_squared[38:5], zero pad[39]
    output logic [thgg_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // distance_valid[0]
    output logic                              m_axis_tuser
);
    import thgg_pkg::*;

    localparam int PROD_W = 2 * COORD_BITS;
    localparam int SQ_W   = 2 * COORD_BITS + 1;

    t_cfg                     cfg;
    t_pipe_ctrl               dec_ctrl;

    logic                     r_v1;
    logic                     r_v2;
    logic                     r_v3;
    logic                     adv1;
    logic                     adv2;
    logic                     adv3;

    logic                     r_s1_both;
    logic [TIME_BITS-1:0]     r_s1_now;
    logic [VEC_W-1:0]         r_s1_lnorm;
    logic [VEC_W-1:0]         r_s1_rnorm;
    logic [VEC_W-1:0]         r_s1_lpos;
    logic [VEC_W-1:0]         r_s1_rpos;

    logic                     s2_both;
    logic [TIME_BITS-1:0]     s2_now;
    logic signed [PROD_W-1:0] s2_dot_term [3];
    logic [SQ_W-1:0]          s2_sq_term  [3];

    logic                     res_armed;
    logic                     res_open;
    logic                     res_close;
    t_zone                    res_zone;
    logic                     res_dvalid;
    logic [DIST_W-1:0]        res_dsq;

    thgg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Each stage advances when it is empty or the stage after it advances, so bubbles
    // collapse and a waiting result blocks intake only once every stage is full.
    assign adv3 = !r_v3 || m_axis_tready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign s_axis_tready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Input register: unpack the transaction, keep only the live time bits
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_both  <= s_axis_tuser;
            r_s1_now   <= TIME_BITS'(s_axis_tdata[TS_LSB +: TS_W]);
            r_s1_lnorm <= s_axis_tdata[LNORM_LSB +: VEC_W];
            r_s1_rnorm <= s_axis_tdata[RNORM_LSB +: VEC_W];
            r_s1_lpos  <= s_axis_tdata[LPOS_LSB +: VEC_W];
            r_s1_rpos  <= s_axis_tdata[RPOS_LSB +: VEC_W];
        end
    end

    thgg_geom #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_geom (
        .i_clk            (i_clk),
        .i_load           (adv2),
        .i_both           (r_s1_both),
        .i_now            (r_s1_now),
        .i_left_normal    (r_s1_lnorm),
        .i_right_normal   (r_s1_rnorm),
        .i_left_position  (r_s1_lpos),
        .i_right_position (r_s1_rpos),
        .o_both           (s2_both),
        .o_now            (s2_now),
        .o_dot_term       (s2_dot_term),
        .o_sq_term        (s2_sq_term)
    );

    // State moves only when a live frame drops into the result register
    assign dec_ctrl.adv = adv3;
    assign dec_ctrl.vld = r_v2;

    thgg_decide #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_decide (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctrl             (dec_ctrl),
        .i_cfg              (cfg),
        .i_both             (s2_both),
        .i_now              (s2_now),
        .i_dot_term         (s2_dot_term),
        .i_sq_term          (s2_sq_term),
        .o_armed            (res_armed),
        .o_open_impulse     (res_open),
        .o_close_impulse    (res_close),
        .o_zone             (res_zone),
        .o_distance_valid   (res_dvalid),
        .o_distance_squared (res_dsq)
    );

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, res_dsq, res_zone, res_close, res_open, res_armed};
    assign m_axis_tuser  = res_dvalid;

`include "assert_macros.svh"

    `ASSERT_NEVER(a_one_impulse, i_clk, i_rst_n, m_axis_tvalid && res_open && res_close, "open and close impulse together")
    `ASSERT_ALWAYS(a_impulse_armed, i_clk, i_rst_n, !(m_axis_tvalid && (res_open || res_close)) || res_armed, "impulse without armed gesture")
    `ASSERT_ALWAYS(a_zone_armed, i_clk, i_rst_n, !(m_axis_tvalid && res_zone != ZONE_UNKNOWN) || (res_armed && res_dvalid), "zone set while not armed")
    `ASSERT_ALWAYS(a_no_hands_zero, i_clk, i_rst_n, !(m_axis_tvalid && !res_dvalid) || (res_dsq == '0 && !res_armed), "distance reported without both hands")

endmodule

`default_nettype wire

### tb/two_hand_gripper_gesture_detector_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for two_hand_gripper_gesture_detector: directed and random frames,
// with a cycle-free prediction of every result. Depends on thgg_pkg and the detector RTL only.

module two_hand_gripper_gesture_detector_test;
    import thgg_pkg::*;

    localparam int CLK_HALF_NS      = 10;
    localparam int RESET_CYCLES     = 4;
    localparam int SETTLE_CYCLES    = 8;       // covers the three-stage latency
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int PHASE_FRAMES     = 240;
    localparam int TIMEOUT_NS       = 4_000_000;

    // Index beyond the register file: the write must be ignored
    localparam t_reg_idx REG_UNUSED = 3'd7;

    // Palm normals, z pointing up or down (Q1.14), x in the low bits
    localparam logic [VEC_W-1:0] PALM_UP   = {16'h4000, 16'h0000, 16'h0000};
    localparam logic [VEC_W-1:0] PALM_DOWN = {16'hC000, 16'h0000, 16'h0000};

    typedef struct packed {
        logic             both_hands;
        logic [TS_W-1:0]  timestamp_ms;
        logic [VEC_W-1:0] left_normal;
        logic [VEC_W-1:0] right_normal;
        logic [VEC_W-1:0] left_position;
        logic [VEC_W-1:0] right_position;
    } t_frame;

    typedef struct packed {
        logic              armed;
        logic              open_impulse;
        logic              close_impulse;
        t_zone             zone;
        logic              distance_valid;
        logic [DIST_W-1:0] distance_squared;
    } t_gesture_result;

    // ---------------------------------------------------------------- DUT
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_AW-1:0]     paddr         = '0;
    logic [APB_DW-1:0]     pwdata        = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // timestamp_ms, left_normal, right_normal, left_position, right_position
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    // both_hands
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // armed, open_impulse, close_impulse, zone, distance_squared, zero pad
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    // distance_valid
    logic                  m_axis_tuser;

    two_hand_gripper_gesture_detector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- gesture prediction
    // Settings as the block should hold them, starting from the reset values
    logic [CFG_W-1:0] cfg_facing_limit = RST_FACING_DOT_LIMIT;
    logic [CFG_W-1:0] cfg_hold_ms      = RST_HOLD_TIME_MS;
    logic [CFG_W-1:0] cfg_open_dist    = RST_OPEN_DISTANCE;
    logic [CFG_W-1:0] cfg_close_dist   = RST_CLOSE_DISTANCE;
    logic [CFG_W-1:0] cfg_neutral_low  = RST_NEUTRAL_LOW;
    logic [CFG_W-1:0] cfg_neutral_high = RST_NEUTRAL_HIGH;
    logic [CFG_W-1:0] cfg_cooldown_ms  = RST_COOLDOWN_MS;

    // Gesture history carried from frame to frame
    logic             facing_active   = 1'b0;
    logic [TS_W-1:0]  facing_since_ms = '0;
    t_zone            last_zone       = ZONE_UNKNOWN;
    logic             impulse_fired   = 1'b0;
    logic [TS_W-1:0]  last_impulse_ms = '0;

    function automatic longint axis(input logic [VEC_W-1:0] vec, input int k);
        logic signed [15:0] c;
        c = vec[16*k +: 16];
        return longint'(c);
    endfunction

    function automatic t_gesture_result next_gesture_result(input t_frame f);
        t_gesture_result r;
        longint          dot, lim, d;
        logic [63:0]     dsq, open_sq, close_sq, low_sq, high_sq;
        logic [TS_W-1:0] elapsed;
        logic            cool_ok;
        int              k;
        r = '0;
        if (!f.both_hands) begin
            // hands missing: drop the facing timer and the zone history
            facing_active = 1'b0;
            last_zone     = ZONE_UNKNOWN;
            return r;
        end
        dot = 0;
        dsq = '0;
        for (k = 0; k < 3; k++) begin
            dot += axis(f.left_normal, k) * axis(f.right_normal, k);
            d    = axis(f.left_position, k) - axis(f.right_position, k);
            dsq += d * d;
        end
        r.distance_valid   = 1'b1;
        r.distance_squared = (dsq > {DIST_W{1'b1}}) ? {DIST_W{1'b1}} : dsq[DIST_W-1:0];

        // Q1.14 times Q1.14 is Q2.28: align the limit by 14 bits
        lim = longint'($signed(cfg_facing_limit));
        if (dot < lim * 16384) begin
            if (!facing_active) begin
                facing_active   = 1'b1;
                facing_since_ms = f.timestamp_ms;
            end
            elapsed = f.timestamp_ms - facing_since_ms;
            r.armed = (elapsed >= TS_W'(cfg_hold_ms));
        end else begin
            facing_active = 1'b0;
        end

        if (!r.armed) begin
            last_zone = ZONE_UNKNOWN;
            return r;
        end

        // Fixed order of tests, so overlapping thresholds resolve to open first
        open_sq  = 64'(cfg_open_dist) * 64'(cfg_open_dist);
        close_sq = 64'(cfg_close_dist) * 64'(cfg_close_dist);
        low_sq   = 64'(cfg_neutral_low) * 64'(cfg_neutral_low);
        high_sq  = 64'(cfg_neutral_high) * 64'(cfg_neutral_high);
        if (dsq > open_sq)
            r.zone = ZONE_OPEN;
        else if (dsq < close_sq)
            r.zone = ZONE_CLOSE;
        else if (dsq > low_sq && dsq < high_sq)
            r.zone = ZONE_NEUTRAL;
        else
            r.zone = ZONE_UNKNOWN;

        elapsed = f.timestamp_ms - last_impulse_ms;
        cool_ok = !impulse_fired || (elapsed > TS_W'(cfg_cooldown_ms));
        if (cool_ok && r.zone == ZONE_OPEN &&
            (last_zone == ZONE_NEUTRAL || last_zone == ZONE_CLOSE)) begin
            r.open_impulse = 1'b1;
        end else if (cool_ok && r.zone == ZONE_CLOSE &&
                     (last_zone == ZONE_NEUTRAL || last_zone == ZONE_OPEN)) begin
            r.close_impulse = 1'b1;
        end
        if (r.open_impulse || r.close_impulse) begin
            impulse_fired   = 1'b1;
            last_impulse_ms = f.timestamp_ms;
        end
        last_zone = r.zone;
        return r;
    endfunction

    // ---------------------------------------------------------------- frame driver
    t_frame          pending_frames[$];
    t_gesture_result pending_gesture_results[$];
    t_frame          frame_on_bus;
    int              sender_idle_pct   = 20;
    int              receiver_idle_pct = 72;

    always @(posedge i_clk) begin : frame_driver
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            // Predict on the transaction that completes at this edge
            if (s_axis_tvalid && s_axis_tready)
                pending_gesture_results.push_back(next_gesture_result(frame_on_bus));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_frames.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
                    frame_on_bus = pending_frames.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {frame_on_bus.right_position, frame_on_bus.left_position,
                                      frame_on_bus.right_normal, frame_on_bus.left_normal,
                                      frame_on_bus.timestamp_ms};
                    s_axis_tuser  <= frame_on_bus.both_hands;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- result monitor
    int error_count        = 0;
    int results_checked    = 0;
    int armed_seen         = 0;
    int open_seen          = 0;
    int close_seen         = 0;
    int handless_seen      = 0;
    int long_hold_requests = 0;
    int long_holds_served  = 0;
    int hold_left          = 0;

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            error_count++;
        end
    endtask

    // Count out a long hold-off of the receiver once it is requested
    always @(posedge i_clk) begin : long_hold_counter
        if (long_holds_served != long_hold_requests) begin
            long_holds_served <= long_hold_requests;
            hold_left         <= LONG_HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_gesture_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_gesture_results.size() == 0) begin
                    $error("result transaction with no frame awaiting its result");
                    error_count++;
                end else begin
                    want = pending_gesture_results.pop_front();
                    check_field("armed", 64'(want.armed), 64'(m_axis_tdata[0]));
                    check_field("open_impulse", 64'(want.open_impulse), 64'(m_axis_tdata[1]));
                    check_field("close_impulse", 64'(want.close_impulse),
                                64'(m_axis_tdata[2]));
                    check_field("zone", 64'(want.zone), 64'(m_axis_tdata[4:3]));
                    check_field("distance_squared", 64'(want.distance_squared),
                                64'(m_axis_tdata[DIST_W+4:5]));
                    check_field("tdata pad", '0, 64'(m_axis_tdata[M_TDATA_W-1:M_FIELDS_W]));
                    check_field("distance_valid", 64'(want.distance_valid), 64'(m_axis_tuser));
                    results_checked++;
                    armed_seen    += int'(want.armed);
                    open_seen     += int'(want.open_impulse);
                    close_seen    += int'(want.close_impulse);
                    handless_seen += int'(!want.distance_valid);
                end
            end
            // Long hold-off on request, else random back-pressure
            if (long_holds_served != long_hold_requests || hold_left != 0) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99, 0) >= receiver_idle_pct);
            end
        end
    end

    // ---------------------------------------------------------------- stimulus helpers
    function automatic logic [VEC_W-1:0] vec3(input int x, input int y, input int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    task automatic queue_frame(input logic both, input logic [TS_W-1:0] ts,
                               input logic [VEC_W-1:0] ln, input logic [VEC_W-1:0] rn,
                               input logic [VEC_W-1:0] lp, input logic [VEC_W-1:0] rp);
        t_frame f;
        f.both_hands     = both;
        f.timestamp_ms   = ts;
        f.left_normal    = ln;
        f.right_normal   = rn;
        f.left_position  = lp;
        f.right_position = rp;
        pending_frames.push_back(f);
    endtask

    // Left palm up at the origin, right palm at sep along x
    task automatic directed_frame(input logic [TS_W-1:0] ts, input logic [VEC_W-1:0] rn,
                                  input int sep);
        queue_frame(1'b1, ts, PALM_UP, rn, '0, vec3(sep, 0, 0));
    endtask

    // Separation aimed at one of the zones, right on a threshold, or random over a wide range
    function automatic int pick_separation();
        case ($urandom_range(5, 0))
            0: return (cfg_close_dist == 0) ? 0 : $urandom_range(cfg_close_dist - 1, 0);
            1: begin
                if (cfg_neutral_high > cfg_neutral_low + 1)
                    return $urandom_range(cfg_neutral_high - 1, cfg_neutral_low + 1);
                return $urandom_range(4000, 0);
            end
            2: return $urandom_range(cfg_open_dist + 3000, cfg_open_dist + 1);
            3: begin
                case ($urandom_range(3, 0))
                    0: return int'(cfg_open_dist);
                    1: return int'(cfg_close_dist);
                    2: return int'(cfg_neutral_low);
                    default: return int'(cfg_neutral_high);
                endcase
            end
            default: return $urandom_range(45000, 0);
        endcase
    endfunction

    // Palms facing, time advancing steadily, hands moving between zones
    task automatic gesture_run(input int frames);
        logic [TS_W-1:0]  now;
        logic [VEC_W-1:0] ln, rn;
        logic             both;
        int lx, ly, lz, rx, jx, jy, sep, dwell, step_max, i;
        now      = $urandom();
        step_max = 2 + int'((cfg_hold_ms > cfg_cooldown_ms) ? cfg_hold_ms : cfg_cooldown_ms) / 6;
        lx       = int'($urandom_range(20000, 0)) - 20000;
        ly       = int'($urandom_range(20000, 0)) - 10000;
        lz       = int'($urandom_range(20000, 0)) - 10000;
        dwell    = 0;
        sep      = 0;
        for (i = 0; i < frames; i++) begin
            if (dwell == 0) begin
                sep   = pick_separation();
                dwell = $urandom_range(6, 1);
            end
            dwell--;
            rx = (lx + sep > 32767) ? 32767 : lx + sep;
            jx = int'($urandom_range(1200, 0)) - 600;
            jy = int'($urandom_range(1200, 0)) - 600;
            ln = vec3(jx, jy, 16384 - int'($urandom_range(800, 0)));
            rn = vec3(int'($urandom_range(100, 0)) - 50 - jx, -jy,
                      int'($urandom_range(800, 0)) - 16384);
            both = 1'b1;
            // Break the sequence now and then: a hand lost or the palms turned away
            case ($urandom_range(49, 0))
                0: both = 1'b0;
                1, 2: rn = ln;
                default: ;
            endcase
            queue_frame(both, now, ln, rn, vec3(lx, ly, lz), vec3(rx, ly, lz));
            now += $urandom_range(step_max, 1);
        end
    endtask

    task automatic random_frames(input int count);
        int made, len;
        made = 0;
        while (made < count) begin
            if ($urandom_range(99, 0) < 80) begin
                len = $urandom_range(70, 20);
                if (len > count - made)
                    len = count - made;
                gesture_run(len);
                made += len;
            end else begin
                // Noise: every field random over its full width
                queue_frame(1'($urandom_range(1, 0)), $urandom(),
                            48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                            48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}));
                made++;
            end
        end
    endtask

    // Hold until every frame has been sent and every result has come back
    task automatic drain_results();
        @(negedge i_clk);
        while (pending_frames.size() != 0 || s_axis_tvalid ||
               pending_gesture_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_setting(input t_reg_idx idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom()), value};    // upper half must be dropped
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FACING_DOT_LIMIT: cfg_facing_limit = value;
            REG_HOLD_TIME_MS:     cfg_hold_ms      = value;
            REG_OPEN_DISTANCE:    cfg_open_dist    = value;
            REG_CLOSE_DISTANCE:   cfg_close_dist   = value;
            REG_NEUTRAL_LOW:      cfg_neutral_low  = value;
            REG_NEUTRAL_HIGH:     cfg_neutral_high = value;
            REG_COOLDOWN_MS:      cfg_cooldown_ms  = value;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] limit, input logic [CFG_W-1:0] hold,
                                 input logic [CFG_W-1:0] open_d, input logic [CFG_W-1:0] close_d,
                                 input logic [CFG_W-1:0] low_d, input logic [CFG_W-1:0] high_d,
                                 input logic [CFG_W-1:0] cool);
        write_setting(REG_FACING_DOT_LIMIT, limit);
        write_setting(REG_HOLD_TIME_MS, hold);
        write_setting(REG_OPEN_DISTANCE, open_d);
        write_setting(REG_CLOSE_DISTANCE, close_d);
        write_setting(REG_NEUTRAL_LOW, low_d);
        write_setting(REG_NEUTRAL_HIGH, high_d);
        write_setting(REG_COOLDOWN_MS, cool);
    endtask

    // Idle pattern per phase: sender light and receiver heavy, the reverse, or none
    task automatic run_phase(input int mode, input int frames);
        case (mode % 3)
            0: begin sender_idle_pct = 20; receiver_idle_pct = 72; end
            1: begin sender_idle_pct = 72; receiver_idle_pct = 20; end
            default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
        endcase
        @(negedge i_clk);
        random_frames(frames);
        drain_results();
    endtask

    // ---------------------------------------------------------------- test sequence
    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames at the reset settings
        // hands missing, every other input bit set
        queue_frame(1'b0, '1, '1, '1, '1, '1);
        // hands seen, all zero: not facing, zero separation
        queue_frame(1'b1, '0, '0, '0, '0, '0);
        // widest coordinates: hard facing, largest separation, just before the time wrap
        queue_frame(1'b1, 32'hFFFF_FFF0,
                    vec3(-32768, -32768, -32768), vec3(32767, 32767, 32767),
                    vec3(-32768, -32768, -32768), vec3(32767, 32767, 32767));
        // facing timer spans the wrap: armed, neutral
        directed_frame(32'd1000, PALM_DOWN, 1500);
        // open from neutral, first impulse with no cooldown history
        directed_frame(32'd1010, PALM_DOWN, 2500);
        // close from open inside the cooldown: suppressed
        directed_frame(32'd1020, PALM_DOWN, 500);
        // open from close once the cooldown has passed
        directed_frame(32'd1530, PALM_DOWN, 2500);
        directed_frame(32'd1540, PALM_DOWN, 1500);
        // elapsed time equal to the cooldown: still suppressed
        directed_frame(32'd2030, PALM_DOWN, 500);
        directed_frame(32'd2031, PALM_DOWN, 1500);
        directed_frame(32'd2040, PALM_DOWN, 500);
        // gap between close and neutral, then each threshold exactly
        directed_frame(32'd2050, PALM_DOWN, 1000);
        directed_frame(32'd2060, PALM_DOWN, 2000);
        directed_frame(32'd2070, PALM_DOWN, 800);
        directed_frame(32'd2080, PALM_DOWN, 1100);
        directed_frame(32'd2085, PALM_DOWN, 1700);
        // palms turned the same way: not armed, timer cleared
        directed_frame(32'd2090, PALM_UP, 1500);
        // timer restarts; one short of the hold time, then exactly on it
        directed_frame(32'd2100, PALM_DOWN, 1500);
        directed_frame(32'd2399, PALM_DOWN, 1500);
        directed_frame(32'd2400, PALM_DOWN, 1500);
        directed_frame(32'd3000, PALM_DOWN, 2500);
        queue_frame(1'b0, 32'd3010, PALM_UP, PALM_DOWN, '0, vec3(500, 0, 0));
        // dot product equal to the limit does not face; one step further does
        directed_frame(32'd3020, vec3(0, 0, -11469), 500);
        directed_frame(32'd3030, vec3(0, 0, -11470), 500);
        directed_frame(32'd3330, vec3(0, 0, -11470), 3000);

        run_phase(0, PHASE_FRAMES);

        // Any facing arms at once, no cooldown, neutral band inside the gap
        load_settings(16'h0000, 16'd0, 16'd1500, 16'd1000, 16'd1000, 16'd1500, 16'd0);
        run_phase(1, PHASE_FRAMES);

        // Upper extremes; hold the receiver off long enough to back up the input
        load_settings(16'd16384, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        long_hold_requests++;
        run_phase(2, PHASE_FRAMES);

        // Lowest facing limit, overlapping zones, stray write past the register file
        load_settings(-16'sd16384, 16'd50, 16'd500, 16'd1500, 16'd200, 16'd3000, 16'd100);
        write_setting(REG_UNUSED, 16'($urandom()));
        run_phase(3, PHASE_FRAMES);

        load_settings(16'($urandom_range(32768, 0) - 16384), 16'($urandom_range(400, 0)),
                      16'($urandom_range(4000, 1500)), 16'($urandom_range(1200, 300)),
                      16'($urandom_range(1400, 700)), 16'($urandom_range(2500, 1300)),
                      16'($urandom_range(800, 0)));
        run_phase(4, PHASE_FRAMES);

        load_settings(RST_FACING_DOT_LIMIT, RST_HOLD_TIME_MS, RST_OPEN_DISTANCE,
                      RST_CLOSE_DISTANCE, RST_NEUTRAL_LOW, RST_NEUTRAL_HIGH, RST_COOLDOWN_MS);
        run_phase(5, PHASE_FRAMES);

        $display("Checked %0d frames over six register settings and one long output stall.",
                 results_checked);
        $display("Seen: %0d armed, %0d open and %0d close impulses, %0d without both hands.",
                 armed_seen, open_seen, close_seen, handless_seen);
        if (error_count == 0 && pending_gesture_results.size() == 0) begin
            $display("two_hand_gripper_gesture_detector_test passed");
        end else begin
            $display("two_hand_gripper_gesture_detector_test failed");
        end
        $finish;
    end

    // Stop a run that hangs
    initial begin : watchdog
        #TIMEOUT_NS;
        $display("Timed out with %0d results outstanding", pending_gesture_results.size());
        $display("two_hand_gripper_gesture_detector_test failed");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/thgg_pkg.sv
hw/rtl/thgg_cfg.sv
hw/rtl/thgg_geom.sv
hw/rtl/thgg_decide.sv
hw/rtl/two_hand_gripper_gesture_detector.sv
tb/two_hand_gripper_gesture_detector_test.sv
